// File: design/icu_pkg.sv
// Shared types and constants for the masked priority interrupt controller.
package icu_pkg;

    localparam int LINE_COUNT_DEF = 16;
    localparam int MASK_W         = 16;

    localparam logic [2:0] MODE_READ  = 3'd0;
    localparam logic [2:0] MODE_WRITE = 3'd1;
    localparam logic [2:0] MODE_RAISE = 3'd2;
    localparam logic [2:0] MODE_CLEAR = 3'd3;
    localparam logic [2:0] MODE_NOP   = 3'd4;

    localparam logic [26:0] ADDR_STATUS = 27'h7FFFFF4;
    localparam logic [26:0] ADDR_MASK   = 27'h7FFFFF5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [26:0] bus_address;
        logic [15:0] bus_write_data;
        logic [15:0] line_index;
        logic [31:0] line_vector;
    } icu_item_t;

    typedef struct packed {
        logic [15:0] bus_read_data;
        logic        irq_active;
        logic [31:0] irq_vector;
        logic        write_fault;
    } icu_result_t;

endpackage

// File: design/icu_prio_enc.sv
// Fixed priority encoder: lowest set bit wins.
module icu_prio_enc #(
    parameter int LINE_COUNT = 16,
    parameter int LW         = 4
) (
    input  logic [LINE_COUNT-1:0] live,
    output logic                  found,
    output logic [LW-1:0]         idx
);
    always_comb
    begin
        idx = '0;
        for (int i = LINE_COUNT - 1; i >= 0; i--)
        begin
            if (live[i])
            begin
                idx = LW'(i);
            end
        end
    end

    assign found = |live;

endmodule

// File: design/icu_state.sv
// Pending, mask and vector storage with command decode and vector read port.
module icu_state #(
    parameter int LINE_COUNT = 16,
    parameter int LW         = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_vld,
    input  icu_pkg::icu_item_t    cmd,
    input  logic [LW-1:0]         vec_idx,
    output logic [LINE_COUNT-1:0] pending_nx,
    output logic [LINE_COUNT-1:0] mask_nx,
    output logic [15:0]           rd_data,
    output logic                  fault,
    output logic [31:0]           vec_data
);
    import icu_pkg::*;

    logic [LINE_COUNT-1:0] pending_reg;
    logic [LINE_COUNT-1:0] pending_next;
    logic [MASK_W-1:0]     mask_reg;
    logic [MASK_W-1:0]     mask_next;
    logic [31:0]           vec_reg [LINE_COUNT];
    logic                  in_range;
    logic                  raise;
    logic                  clear;
    logic                  mask_wr;
    logic [LW-1:0]         line;
    logic [LINE_COUNT-1:0] line_bit;
    logic [15:0]           status16;

    assign in_range = cmd.line_index < 16'(LINE_COUNT);
    assign line     = cmd.line_index[LW-1:0];
    assign line_bit = LINE_COUNT'(1) << line;
    assign raise    = cmd_vld && cmd.mode == MODE_RAISE && in_range;
    assign clear    = cmd_vld && cmd.mode == MODE_CLEAR && in_range;
    assign mask_wr  = cmd_vld && cmd.mode == MODE_WRITE && cmd.bus_address == ADDR_MASK;

    always_comb
    begin
        pending_next = pending_reg;
        if (raise)
        begin
            pending_next = pending_reg | line_bit;
        end
        else if (clear)
        begin
            pending_next = pending_reg & ~line_bit;
        end
        mask_next = mask_wr ? cmd.bus_write_data : mask_reg;
    end

    // lines above the mask width stay masked; status shows the low pending bits
    for (genvar g = 0; g < LINE_COUNT; g++)
    begin : g_mask
        if (g < MASK_W)
        begin : g_in
            assign mask_nx[g] = mask_next[g];
        end
        else
        begin : g_out
            assign mask_nx[g] = 1'b0;
        end
    end

    for (genvar g = 0; g < 16; g++)
    begin : g_stat
        if (g < LINE_COUNT)
        begin : g_in
            assign status16[g] = pending_reg[g];
        end
        else
        begin : g_out
            assign status16[g] = 1'b0;
        end
    end

    assign pending_nx = pending_next;

    always_comb
    begin
        rd_data = '0;
        fault   = 1'b0;
        if (cmd_vld)
        begin
            case (cmd.mode)
                MODE_READ:
                begin
                    if (cmd.bus_address == ADDR_STATUS)
                    begin
                        rd_data = status16;
                    end
                    else if (cmd.bus_address == ADDR_MASK)
                    begin
                        rd_data = mask_reg;
                    end
                end
                MODE_WRITE:
                begin
                    fault = cmd.bus_address == ADDR_STATUS;
                end
                default:
                begin
                    rd_data = '0;
                end
            endcase
        end
    end

    // bypass the vector being written this cycle
    assign vec_data = (raise && line == vec_idx) ? cmd.line_vector : vec_reg[vec_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            mask_reg    <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            mask_reg    <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (raise)
        begin
            vec_reg[line] <= cmd.line_vector;
        end
    end

endmodule

// File: design/masked_priority_interrupt_controller_unit.sv
// Masked fixed-priority vectored interrupt controller, top level.
// An accepted transfer is registered in the input stage, then its result and done are registered.
// Throughput: one item per cycle; busy never rises and done cannot be held off.
// The result reflects pending and mask state after that item's own update.
// Reset clears pending bits, mask and pipeline valids; line vectors are undefined until raised.
module masked_priority_interrupt_controller_unit #(
    parameter int LINE_COUNT = icu_pkg::LINE_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  icu_pkg::icu_item_t  cmd,
    output logic                done,
    output icu_pkg::icu_result_t result
);
    import icu_pkg::*;

    localparam int LW = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;

    logic                  in_vld_reg;
    icu_item_t             in_item_reg;
    logic                  done_reg;
    icu_result_t           res_reg;
    icu_result_t           res_next;
    logic [LINE_COUNT-1:0] pending_nx;
    logic [LINE_COUNT-1:0] mask_nx;
    logic [LINE_COUNT-1:0] live;
    logic                  found;
    logic [LW-1:0]         win_idx;
    logic [15:0]           rd_data;
    logic                  fault;
    logic [31:0]           vec_data;

    assign busy = 1'b0;

    icu_state #(
        .LINE_COUNT(LINE_COUNT),
        .LW        (LW)
    ) u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_vld   (in_vld_reg),
        .cmd       (in_item_reg),
        .vec_idx   (win_idx),
        .pending_nx(pending_nx),
        .mask_nx   (mask_nx),
        .rd_data   (rd_data),
        .fault     (fault),
        .vec_data  (vec_data)
    );

    assign live = pending_nx & mask_nx;

    icu_prio_enc #(
        .LINE_COUNT(LINE_COUNT),
        .LW        (LW)
    ) u_prio (
        .live (live),
        .found(found),
        .idx  (win_idx)
    );

    always_comb
    begin
        res_next.bus_read_data = rd_data;
        res_next.irq_active    = found;
        res_next.irq_vector    = found ? vec_data : 32'h0;
        res_next.write_fault   = fault;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start && !busy;
            done_reg   <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_item_reg <= cmd;
        end
        if (in_vld_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> in_vld_reg)
        else $error("accepted transfer did not enter the input stage");

    a_stage_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg |=> done)
        else $error("input stage item produced no result");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |=> !done)
        else $error("result strobe without an item");

    a_idle_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.irq_active) |-> result.irq_vector == 32'h0)
        else $error("vector nonzero while no line is active");

    a_fault_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.write_fault) |-> result.bus_read_data == 16'h0)
        else $error("write fault with read data");

endmodule

// File: verif/tb.sv
// Testbench for the interrupt controller: directed table, then random transfers vs. predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import icu_pkg::*;

    localparam int LINE_COUNT = LINE_COUNT_DEF;
    localparam int RAND_ITEMS = 1525;
    localparam int CALM_ITEMS = 200;
    localparam int CYCLE_LIMIT = 250000;

    localparam logic [2:0] MODE_SPARE5 = 3'd5;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    typedef struct {
        icu_item_t   item;
        bit          fixed;
        icu_result_t res;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    icu_item_t   cmd = '0;
    logic        done;
    icu_result_t result;

    logic [15:0] pend_model;
    logic [15:0] mask_model;
    logic [31:0] vec_model [LINE_COUNT];

    icu_result_t irq_status_q [$];
    row_t        dir_tbl [$];
    bit          idle_ok;
    int          errs;
    int          checked;
    int          cycles;
    int          n_read, n_write, n_raise, n_clear, n_other;

    masked_priority_interrupt_controller_unit #(
        .LINE_COUNT(LINE_COUNT)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic icu_result_t apply_command(icu_item_t it);
        icu_result_t r;
        logic [15:0] live;
        int          i;
        r = '0;
        case (it.mode)
            MODE_READ:
            begin
                if (it.bus_address == ADDR_STATUS)
                    r.bus_read_data = pend_model;
                else if (it.bus_address == ADDR_MASK)
                    r.bus_read_data = mask_model;
            end
            MODE_WRITE:
            begin
                if (it.bus_address == ADDR_STATUS)
                    r.write_fault = 1'b1;
                else if (it.bus_address == ADDR_MASK)
                    mask_model = it.bus_write_data;
            end
            MODE_RAISE:
            begin
                if (it.line_index < LINE_COUNT)
                begin
                    vec_model[it.line_index[3:0]] = it.line_vector;
                    pend_model[it.line_index[3:0]] = 1'b1;
                end
            end
            MODE_CLEAR:
            begin
                if (it.line_index < LINE_COUNT)
                    pend_model[it.line_index[3:0]] = 1'b0;
            end
            default: ;
        endcase
        live = pend_model & mask_model;
        r.irq_active = |live;
        for (i = LINE_COUNT - 1; i >= 0; i--)
            if (live[i])
                r.irq_vector = vec_model[i];
        return r;
    endfunction

    function automatic row_t mk_row(logic [2:0] m, logic [26:0] a, logic [15:0] wd,
                                    logic [15:0] ln, logic [31:0] v, bit fx,
                                    logic [15:0] rd, bit act, logic [31:0] iv, bit flt);
        row_t r;
        r.item.mode           = m;
        r.item.bus_address    = a;
        r.item.bus_write_data = wd;
        r.item.line_index     = ln;
        r.item.line_vector    = v;
        r.fixed               = fx;
        r.res.bus_read_data   = rd;
        r.res.irq_active      = act;
        r.res.irq_vector      = iv;
        r.res.write_fault     = flt;
        return r;
    endfunction

    function automatic icu_item_t random_command();
        icu_item_t   it;
        int unsigned pick;
        it.bus_address    = 27'($urandom);
        it.bus_write_data = 16'($urandom);
        it.line_vector    = $urandom;
        it.line_index     = ($urandom_range(0, 6) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, LINE_COUNT - 1));
        pick = $urandom_range(0, 99);
        if (pick < 20)
            it.mode = MODE_READ;
        else if (pick < 35)
            it.mode = MODE_WRITE;
        else if (pick < 65)
            it.mode = MODE_RAISE;
        else if (pick < 85)
            it.mode = MODE_CLEAR;
        else if (pick < 93)
            it.mode = MODE_NOP;
        else
            case ($urandom_range(0, 2))
                0: it.mode = MODE_SPARE5;
                1: it.mode = MODE_SPARE6;
                default: it.mode = MODE_SPARE7;
            endcase
        case ($urandom_range(0, 9))
            0, 1, 2: it.bus_address = ADDR_STATUS;
            3, 4, 5, 6, 7: it.bus_address = ADDR_MASK;
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0: it.bus_write_data = '0;
            1: it.bus_write_data = 16'hFFFF;
            2: it.bus_write_data = 16'(1 << $urandom_range(0, 15));
            default: ;
        endcase
        return it;
    endfunction

    task automatic send(icu_item_t it, bit fixed, icu_result_t typed);
        int unsigned gap;
        icu_result_t want;
        if (idle_ok && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= it;
        do
            @(posedge clk);
        while (busy);
        want = apply_command(it);
        if (fixed)
            want = typed;
        irq_status_q.push_back(want);
        case (it.mode)
            MODE_READ:  n_read++;
            MODE_WRITE: n_write++;
            MODE_RAISE: n_raise++;
            MODE_CLEAR: n_clear++;
            default:    n_other++;
        endcase
    endtask

    task automatic drain();
        start <= 1'b0;
        while (irq_status_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        icu_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (irq_status_q.size() == 0)
            begin
                $error("result transfer with no prediction waiting");
                errs++;
            end
            else
            begin
                want = irq_status_q.pop_front();
                checked++;
                if (result.bus_read_data !== want.bus_read_data)
                begin
                    $error("bus_read_data: expected %h, got %h",
                           want.bus_read_data, result.bus_read_data);
                    errs++;
                end
                if (result.irq_active !== want.irq_active)
                begin
                    $error("irq_active: expected %b, got %b", want.irq_active, result.irq_active);
                    errs++;
                end
                if (result.irq_vector !== want.irq_vector)
                begin
                    $error("irq_vector: expected %h, got %h", want.irq_vector, result.irq_vector);
                    errs++;
                end
                if (result.write_fault !== want.write_fault)
                begin
                    $error("write_fault: expected %b, got %b",
                           want.write_fault, result.write_fault);
                    errs++;
                end
            end
        end
    end

    initial
    begin
        pend_model = '0;
        mask_model = '0;
        idle_ok    = 1'b1;

        dir_tbl.push_back(mk_row(MODE_READ, ADDR_STATUS, 16'h0, 16'h0, 32'h0,
                                 1, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_READ, ADDR_MASK, 16'h0, 16'h0, 32'h0,
                                 1, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_WRITE, ADDR_STATUS, 16'hFFFF, 16'h0, 32'h0,
                                 1, 16'h0, 0, 32'h0, 1));
        dir_tbl.push_back(mk_row(MODE_RAISE, 27'h0, 16'h0, 16'd0, 32'hFFFF_FFFF,
                                 1, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_READ, ADDR_STATUS, 16'h0, 16'h0, 32'h0,
                                 1, 16'h0001, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_WRITE, ADDR_MASK, 16'hFFFF, 16'h0, 32'h0,
                                 1, 16'h0, 1, 32'hFFFF_FFFF, 0));
        dir_tbl.push_back(mk_row(MODE_READ, ADDR_MASK, 16'h0, 16'h0, 32'h0,
                                 1, 16'hFFFF, 1, 32'hFFFF_FFFF, 0));
        dir_tbl.push_back(mk_row(MODE_RAISE, 27'h0, 16'h0, 16'd15, 32'h0,
                                 0, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_RAISE, 27'h0, 16'h0, 16'd16, 32'h1234_5678,
                                 0, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_RAISE, 27'h0, 16'h0, 16'hFFFF, 32'hA5A5_A5A5,
                                 0, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_CLEAR, 27'h0, 16'h0, 16'd0, 32'h0,
                                 0, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_READ, ADDR_STATUS, 16'h0, 16'h0, 32'h0,
                                 0, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_CLEAR, 27'h0, 16'h0, 16'hFFFF, 32'h0,
                                 0, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_CLEAR, 27'h0, 16'h0, 16'd16, 32'h0,
                                 0, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_WRITE, 27'h0, 16'h0, 16'h0, 32'h0,
                                 0, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_READ, 27'h0, 16'h0, 16'h0, 32'h0,
                                 0, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_WRITE, 27'h7FF_FFFF, 16'h0, 16'h0, 32'h0,
                                 0, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_READ, 27'h7FF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                 0, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_NOP, 27'h7FF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                 0, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_SPARE5, ADDR_MASK, 16'h0, 16'd1, 32'h0,
                                 0, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_SPARE6, ADDR_STATUS, 16'h0, 16'd2, 32'h0,
                                 0, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_SPARE7, ADDR_MASK, 16'h0, 16'd15, 32'h0,
                                 0, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_WRITE, ADDR_MASK, 16'h0, 16'h0, 32'h0,
                                 1, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_RAISE, 27'h0, 16'h0, 16'd7, 32'h7777_0007,
                                 0, 16'h0, 0, 32'h0, 0));
        dir_tbl.push_back(mk_row(MODE_WRITE, ADDR_MASK, 16'h0080, 16'h0, 32'h0,
                                 0, 16'h0, 0, 32'h0, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tbl[k])
            send(dir_tbl[k].item, dir_tbl[k].fixed, dir_tbl[k].res);
        drain();

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            idle_ok = (n < RAND_ITEMS - CALM_ITEMS);
            if (n == RAND_ITEMS / 2)
                drain();
            send(random_command(), 1'b0, '0);
        end
        drain();
        repeat (8) @(posedge clk);

        $display("Checked %0d results from %0d reads, %0d writes, %0d raises, %0d clears",
                 checked, n_read, n_write, n_raise, n_clear);
        $display("and %0d no-op or spare-mode transfers, with idle gaps on the command side",
                 n_other);
        if (errs == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: masked_priority_interrupt_controller_unit.f
design/icu_pkg.sv
design/icu_prio_enc.sv
design/icu_state.sv
design/masked_priority_interrupt_controller_unit.sv
verif/tb.sv
